// ===== sv/rra_pkg.sv =====
// Shared types and constants for the rounded rectangle pixel shader.
package rra_pkg;

  // Field and register widths
  localparam int PIX_W      = 10;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_RAD_W  = 10;
  localparam int COLOR_W    = 32;
  localparam int ALPHA_W    = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Doubled offset, squares, sqrt datapath
  localparam int D_W     = CFG_RAD_W + 1;
  localparam int SQ_W    = 2 * D_W;
  localparam int S_W     = SQ_W + 1;
  localparam int FRAC_SH = 16;
  localparam int Q_W     = (S_W + FRAC_SH + 1) / 2;
  localparam int RAD_W   = 2 * Q_W;
  localparam int REM_W   = Q_W + 2;

  // Register map (word index)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CORNER_RAD   = 2'd2;
  localparam logic [1:0] REG_FILL_COLOR   = 2'd3;

  // Reset values
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_DIM = CFG_DIM_W'(1);
  localparam logic [CFG_RAD_W-1:0] RST_RADIUS    = '0;
  localparam logic [COLOR_W-1:0]   RST_COLOR     = '0;

  // Pixel classification carried down the pipe
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_SOLID,
    KIND_EDGE,
    KIND_ARC
  } kind_t;

  // Saturated configuration and derived squares
  typedef struct packed {
    logic [CFG_DIM_W-1:0] w;
    logic [CFG_DIM_W-1:0] h;
    logic [CFG_RAD_W-1:0] r;
    logic [SQ_W-1:0]      inner_sq;
    logic [SQ_W-1:0]      outer_sq;
    logic [COLOR_W-1:0]   color;
  } cfg_t;

  // One beat moving through the square root cells
  typedef struct packed {
    logic            vld;
    kind_t           kind;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   root;
  } root_beat_t;

endpackage

// ===== sv/rra_regs.sv =====
// APB configuration registers with saturation and radius squares.
module rra_regs import rra_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  localparam int DIM_LIM_I = (MAX_DIM < 2047) ? MAX_DIM : 2047;
  localparam int RAD_LIM_I = (MAX_DIM / 2 < 1023) ? MAX_DIM / 2 : 1023;
  localparam logic [CFG_DIM_W-1:0] DIM_LIM = CFG_DIM_W'(DIM_LIM_I);
  localparam logic [CFG_RAD_W-1:0] RAD_LIM = CFG_RAD_W'(RAD_LIM_I);

  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [CFG_RAD_W-1:0] radius_r;
  logic [COLOR_W-1:0]   color_r;
  logic [SQ_W-1:0]      inner_sq_r, outer_sq_r;
  logic [SQ_W-1:0]      inner_sq_nxt, outer_sq_nxt;
  logic [CFG_RAD_W-1:0] r_sat;
  logic [D_W-1:0]       inner, outer;
  logic                 wr_en;

  assign wr_en = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_DIM;
      height_r <= RST_FRAME_DIM;
      radius_r <= RST_RADIUS;
      color_r  <= RST_COLOR;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[CFG_DIM_W-1:0];
        REG_CORNER_RAD:   radius_r <= pwdata[CFG_RAD_W-1:0];
        REG_FILL_COLOR:   color_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(height_r);
      REG_CORNER_RAD:   prdata = DATA_W'(radius_r);
      REG_FILL_COLOR:   prdata = color_r;
      default:          prdata = '0;
    endcase
  end

  // clamp sizes to the supported frame
  assign r_sat = (radius_r > RAD_LIM) ? RAD_LIM : radius_r;
  assign cfg.w = (width_r > DIM_LIM) ? DIM_LIM : width_r;
  assign cfg.h = (height_r > DIM_LIM) ? DIM_LIM : height_r;
  assign cfg.r = r_sat;
  assign cfg.color = color_r;

  // (2r-1)^2 and (2r+1)^2, registered from the saturated radius register
  assign inner = {r_sat, 1'b0} - D_W'(1);
  assign outer = {r_sat, 1'b1};
  assign inner_sq_nxt = SQ_W'(inner) * SQ_W'(inner);
  assign outer_sq_nxt = SQ_W'(outer) * SQ_W'(outer);

  always_ff @(posedge clk) begin
    inner_sq_r <= inner_sq_nxt;
    outer_sq_r <= outer_sq_nxt;
  end

  assign cfg.inner_sq = inner_sq_r;
  assign cfg.outer_sq = outer_sq_r;

endmodule

// ===== sv/rra_front.sv =====
// Corner selection, doubled offsets, squares and band classification.
module rra_front import rra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [PIX_W-1:0] in_x,
  input  logic [PIX_W-1:0] in_y,
  input  cfg_t             cfg,
  output root_beat_t       beat
);

  logic                 in_frame, left, right, top, bottom;
  logic [CFG_DIM_W-1:0] xr_sum, yr_sum, xr_ofs, yr_ofs;
  logic [CFG_RAD_W-1:0] xl_ofs, yl_ofs;
  logic [D_W-1:0]       ddx_l, ddx_r, ddy_t, ddy_b;

  logic           s1_vld_r;
  kind_t          s1_kind_r, s1_kind_nxt;
  logic [D_W-1:0] s1_ax_r, s1_ax_nxt, s1_ay_r, s1_ay_nxt;

  logic            s2_vld_r;
  kind_t           s2_kind_r;
  logic [SQ_W-1:0] s2_sqx_r, s2_sqy_r;

  logic [S_W-1:0]  s_sum;
  kind_t           s3_kind_nxt;
  logic            s3_vld_r;
  kind_t           s3_kind_r;
  logic [S_W-1:0]  s3_sum_r;

  // stage 1: which corner holds the pixel and its doubled offsets
  assign in_frame = ({1'b0, in_x} < cfg.w) && ({1'b0, in_y} < cfg.h);
  assign xr_sum   = {1'b0, in_x} + CFG_DIM_W'(cfg.r);
  assign yr_sum   = {1'b0, in_y} + CFG_DIM_W'(cfg.r);
  assign left     = in_x < cfg.r;
  assign top      = in_y < cfg.r;
  assign right    = xr_sum >= cfg.w;
  assign bottom   = yr_sum >= cfg.h;

  assign xl_ofs = cfg.r - in_x;
  assign yl_ofs = cfg.r - in_y;
  assign xr_ofs = xr_sum - cfg.w;
  assign yr_ofs = yr_sum - cfg.h;
  assign ddx_l  = {xl_ofs, 1'b0} - D_W'(1);
  assign ddy_t  = {yl_ofs, 1'b0} - D_W'(1);
  assign ddx_r  = {xr_ofs[CFG_RAD_W-1:0], 1'b1};
  assign ddy_b  = {yr_ofs[CFG_RAD_W-1:0], 1'b1};

  always_comb begin
    s1_kind_nxt = KIND_ARC;
    s1_ax_nxt   = ddx_l;
    s1_ay_nxt   = ddy_t;
    if (!in_frame) begin
      s1_kind_nxt = KIND_ZERO;
    end else if (left && top) begin
      s1_ax_nxt = ddx_l;
      s1_ay_nxt = ddy_t;
    end else if (right && top) begin
      s1_ax_nxt = ddx_r;
      s1_ay_nxt = ddy_t;
    end else if (left && bottom) begin
      s1_ax_nxt = ddx_l;
      s1_ay_nxt = ddy_b;
    end else if (right && bottom) begin
      s1_ax_nxt = ddx_r;
      s1_ay_nxt = ddy_b;
    end else begin
      s1_kind_nxt = KIND_SOLID;
    end
  end

  // stage 3: squared distance against the inner and outer circles
  assign s_sum = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};

  always_comb begin
    s3_kind_nxt = s2_kind_r;
    if (s2_kind_r == KIND_ARC) begin
      if (s_sum <= {1'b0, cfg.inner_sq}) begin
        s3_kind_nxt = KIND_SOLID;
      end else if (s_sum < {1'b0, cfg.outer_sq}) begin
        s3_kind_nxt = KIND_EDGE;
      end else begin
        s3_kind_nxt = KIND_ZERO;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // payload; stage 2 squares the offsets
  always_ff @(posedge clk) begin
    s1_kind_r <= s1_kind_nxt;
    s1_ax_r   <= s1_ax_nxt;
    s1_ay_r   <= s1_ay_nxt;
    s2_kind_r <= s1_kind_r;
    s2_sqx_r  <= SQ_W'(s1_ax_r) * SQ_W'(s1_ax_r);
    s2_sqy_r  <= SQ_W'(s1_ay_r) * SQ_W'(s1_ay_r);
    s3_kind_r <= s3_kind_nxt;
    s3_sum_r  <= s_sum;
  end

  // radicand is S scaled by 2^16 so the root carries 8 fraction bits
  assign beat.vld  = s3_vld_r;
  assign beat.kind = s3_kind_r;
  assign beat.rad  = {{(RAD_W - S_W - FRAC_SH){1'b0}}, s3_sum_r, {FRAC_SH{1'b0}}};
  assign beat.rem  = '0;
  assign beat.root = '0;

endmodule

// ===== sv/rra_sqrt_cell.sv =====
// One digit step of the restoring integer square root.
module rra_sqrt_cell import rra_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  root_beat_t beat_in,
  output root_beat_t beat_out
);

  logic [REM_W-1:0] rem_sh, trial;
  logic             fits;
  logic             vld_r;
  root_beat_t       beat_r, beat_nxt;

  // bring down two radicand bits, try root*4+1
  assign rem_sh = {beat_in.rem[REM_W-3:0], beat_in.rad[2*IDX+1 -: 2]};
  assign trial  = {beat_in.root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    beat_nxt      = beat_in;
    beat_nxt.rem  = fits ? (rem_sh - trial) : rem_sh;
    beat_nxt.root = {beat_in.root[Q_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= beat_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  // payload from the data register, valid from the reset register
  always_comb begin
    beat_out     = beat_r;
    beat_out.vld = vld_r;
  end

endmodule

// ===== sv/rra_shade.sv =====
// Edge coverage from the root, alpha scaling and output register.
module rra_shade import rra_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  root_beat_t         beat,
  input  cfg_t               cfg,
  output logic               out_valid,
  output logic [COLOR_W-1:0] out_argb
);

  logic [Q_W-1:0]     outer_q8, diff;
  logic [ALPHA_W-1:0] frac_nxt;

  logic               f1_vld_r;
  kind_t              f1_kind_r;
  logic [ALPHA_W-1:0] f1_frac_r;

  logic [2*ALPHA_W-1:0] alpha_prod;
  logic [COLOR_W-1:0]   argb_nxt;
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_argb_r;

  // coverage = ((2r+1)*256 - q) / 2, clamped to 255
  assign outer_q8 = Q_W'({cfg.r, 1'b1, {ALPHA_W{1'b0}}});
  assign diff     = outer_q8 - beat.root;
  assign frac_nxt = (|diff[Q_W-1:ALPHA_W+1]) ? {ALPHA_W{1'b1}} : diff[ALPHA_W:1];

  // new alpha and final select
  assign alpha_prod = f1_frac_r * cfg.color[COLOR_W-1 -: ALPHA_W];

  always_comb begin
    case (f1_kind_r)
      KIND_SOLID: argb_nxt = cfg.color;
      KIND_EDGE:  argb_nxt = {alpha_prod[2*ALPHA_W-1:ALPHA_W],
                              cfg.color[COLOR_W-ALPHA_W-1:0]};
      default:    argb_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_vld_r    <= beat.vld;
      out_valid_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_kind_r  <= beat.kind;
    f1_frac_r  <= frac_nxt;
    out_argb_r <= argb_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_argb  = out_argb_r;

endmodule

// ===== sv/rounded_rect_aa_pixel.sv =====
// Anti-aliased rounded rectangle pixel shader, top level.
// Pipeline from start to out_valid: 3 front stages, 20 root cells, 2 shade.
// Throughput: one pixel per cycle; each root cell resolves one bit and passes it on.
// busy stays low; results appear for one cycle and cannot be held off.
// Reset (synchronous, rst_n low): pipeline valid bits clear; registers return to
// width 1, height 1, radius 0, color 0.
module rounded_rect_aa_pixel import rra_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [PIX_W-1:0]   in_pixel_x,
  input  logic [PIX_W-1:0]   in_pixel_y,
  output logic               out_valid,
  output logic [COLOR_W-1:0] out_pixel_argb,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t       cfg;
  root_beat_t beat [Q_W+1];
  logic       in_vld;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign in_vld = start & ~busy;

  rra_regs #(
    .MAX_DIM(MAX_DIM)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  rra_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(in_vld),
    .in_x  (in_pixel_x),
    .in_y  (in_pixel_y),
    .cfg   (cfg),
    .beat  (beat[0])
  );

  // root cells, most significant digit first
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    rra_sqrt_cell #(
      .IDX(Q_W - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .beat_in (beat[i]),
      .beat_out(beat[i+1])
    );
  end

  rra_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat[Q_W]),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_argb (out_pixel_argb)
  );

endmodule
